FILE: hdl/chained_hash_key_table_unit_assert.svh
// Assertion macros for the chained hash key table unit
`ifndef CHAINED_HASH_KEY_TABLE_UNIT_ASSERT_SVH
`define CHAINED_HASH_KEY_TABLE_UNIT_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define CHKT_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("chkt assertion failed");

// Next-cycle implication, disabled during reset
`define CHKT_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("chkt assertion failed");

`endif

FILE: hdl/chkt_pkg.sv
// Package: types and constants of the chained hash key table
`timescale 1ns / 1ps
`default_nettype none
package chkt_pkg;

   localparam int unsigned CAPACITY = 256;
   localparam logic [8:0]  NIL_LINK = 9'h100;

   typedef enum logic [2:0] {
      OP_LOOKUP  = 3'd0,
      OP_INSERT  = 3'd1,
      OP_DELETE  = 3'd2,
      OP_FORWARD = 3'd3,
      OP_BACK    = 3'd4,
      OP_BEGIN   = 3'd5,
      OP_END     = 3'd6,
      OP_NONE    = 3'd7
   } op_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_MOD,
      ST_HEAD_RD,
      ST_HEAD_CHK,
      ST_ENT_CHK,
      ST_APPEND,
      ST_LINK,
      ST_RD_CUR,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic [2:0]  operation;
      logic [31:0] key_crc32;
      logic [15:0] key_crc16;
   } req_data_type;

   typedef struct packed {
      logic       success;
      logic [7:0] cursor_position;
      logic       cursor_entry_deleted;
      logic [8:0] live_entries;
      logic [8:0] used_entries;
   } rsp_data_type;

   typedef struct packed {
      logic [47:0] key;
      logic [8:0]  next;
      logic        del;
   } entry_type;

endpackage
`default_nettype wire

FILE: hdl/chkt_req_if.sv
// Valid/ready channel interfaces for requests and responses
`timescale 1ns / 1ps
`default_nettype none
interface chkt_req_if import chkt_pkg::*; ();
   logic         valid;
   logic         ready;
   req_data_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface chkt_rsp_if import chkt_pkg::*; ();
   logic         valid;
   logic         ready;
   rsp_data_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: hdl/chained_hash_key_table_unit.sv
// Chained hash key table: top level.
// Cursor moves, full-table insert and empty-table delete skip the bucket search; lookup/delete
// and insert reduce the key to a bucket by reciprocal multiply, read the bucket head, then do
// one entry-memory read per chain entry; a new key is appended and linked to any old chain tail.
// One transaction in flight; the response register lets the next request in.
// Reset is synchronous; afterwards a clearing pass writes every bucket head,
// with no request accepted until it ends.
`timescale 1ns / 1ps
`default_nettype none
module chained_hash_key_table_unit import chkt_pkg::*; #(
   parameter int unsigned TABLE_SIZE = 256
) (
   input  wire logic  clock,
   input  wire logic  reset,
   chkt_req_if.sink   req_ch,
   chkt_rsp_if.source rsp_ch
);

   localparam int unsigned BW = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
   localparam logic [BW-1:0] LAST_BKT = BW'(TABLE_SIZE - 1);
   localparam logic [BW:0]   TS_VAL   = (BW+1)'(TABLE_SIZE);
   // reciprocal of the table size, scaled so the quotient estimate is at most one low
   localparam int unsigned   RSH      = 33 + BW;
   localparam logic [33:0]   RECIP    = 34'((64'd1 << RSH) / 64'(TABLE_SIZE));
   localparam logic [16:0]   RECIP_LO = RECIP[16:0];
   localparam logic [16:0]   RECIP_HI = RECIP[33:17];

   // memories
   entry_type  ent_mem [CAPACITY];
   logic [8:0] head_mem [TABLE_SIZE];

   state_type    state_ff, state_in;
   op_type       op_ff, op_in;
   logic [47:0]  key_ff, key_in;
   logic [32:0]  sum_ff, sum_in;
   logic [66:0]  acc_ff, acc_in;
   logic [BW:0]  rr_ff, rr_in;
   logic [BW-1:0] rem_ff, rem_in;
   logic [3:0]   mcnt_ff, mcnt_in;
   logic [7:0]   p_ff, p_in;
   entry_type    hold_ff, hold_in;
   logic         empty_ff, empty_in;
   logic [8:0]   used_ff, used_in, live_ff, live_in;
   logic [7:0]   cursor_ff, cursor_in;
   logic         ok_ff, ok_in;
   logic [BW-1:0] clr_ff, clr_in;
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_data_type rsp_data_ff, rsp_data_in;

   entry_type    ent_q, ent_wdata;
   logic         ent_rd_en, ent_we;
   logic [7:0]   ent_raddr, ent_waddr;
   logic [8:0]   head_q, head_wdata;
   logic         head_rd_en, head_we;
   logic [BW-1:0] head_waddr;

   logic accept, hit, last, rsp_load;
   op_type req_op;

   assign req_op    = op_type'(req_ch.data.operation);
   assign accept    = req_ch.valid && req_ch.ready;
   assign hit       = (ent_q.key == key_ff);
   assign last      = ent_q.next[8];
   assign rsp_load  = (state_ff == ST_RESP) && (!rsp_valid_ff || rsp_ch.ready);

   // entry memory
   always_ff @(posedge clock) begin
      if (ent_we) ent_mem[ent_waddr] <= ent_wdata;
      if (ent_rd_en) ent_q <= ent_mem[ent_raddr];
   end

   // bucket head memory
   always_ff @(posedge clock) begin
      if (head_we) head_mem[head_waddr] <= head_wdata;
      if (head_rd_en) head_q <= head_mem[rem_ff];
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: if (clr_ff == LAST_BKT) state_in = ST_IDLE;
         ST_IDLE: begin
            if (req_ch.valid) begin
               case (req_op)
                  OP_LOOKUP: state_in = ST_MOD;
                  OP_INSERT: state_in = used_ff[8] ? ST_RD_CUR : ST_MOD;
                  OP_DELETE: state_in = (used_ff == '0) ? ST_RD_CUR : ST_MOD;
                  default:   state_in = ST_RD_CUR;
               endcase
            end
         end
         ST_MOD: if (mcnt_ff == 4'd3) state_in = ST_HEAD_RD;
         ST_HEAD_RD: state_in = ST_HEAD_CHK;
         ST_HEAD_CHK: begin
            if (!head_q[8]) state_in = ST_ENT_CHK;
            else state_in = (op_ff == OP_INSERT) ? ST_APPEND : ST_RD_CUR;
         end
         ST_ENT_CHK: begin
            if (hit) state_in = ST_RD_CUR;
            else if (last) state_in = (op_ff == OP_INSERT) ? ST_APPEND : ST_RD_CUR;
         end
         ST_APPEND: state_in = empty_ff ? ST_RD_CUR : ST_LINK;
         ST_LINK: state_in = ST_RD_CUR;
         ST_RD_CUR: state_in = ST_RESP;
         ST_RESP: if (rsp_load) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and memory controls
   always_comb begin
      logic [33:0] qv;
      op_in = op_ff; key_in = key_ff; sum_in = sum_ff; rem_in = rem_ff;
      acc_in = acc_ff; rr_in = rr_ff;
      mcnt_in = mcnt_ff; p_in = p_ff; hold_in = hold_ff; empty_in = empty_ff;
      used_in = used_ff; live_in = live_ff; cursor_in = cursor_ff; ok_in = ok_ff;
      clr_in = clr_ff; rsp_data_in = rsp_data_ff;
      ent_rd_en = 1'b0; ent_raddr = p_ff;
      ent_we = 1'b0; ent_waddr = p_ff; ent_wdata = ent_q;
      head_rd_en = 1'b0; head_we = 1'b0; head_waddr = rem_ff; head_wdata = NIL_LINK;
      qv = '0;
      unique case (state_ff)
         ST_CLEAR: begin
            head_we = 1'b1;
            head_waddr = clr_ff;
            clr_in = clr_ff + 1'b1;
         end
         ST_IDLE: begin
            if (req_ch.valid) begin
               op_in  = req_op;
               key_in = {req_ch.data.key_crc16, req_ch.data.key_crc32};
               sum_in = 33'(req_ch.data.key_crc32) + 33'(req_ch.data.key_crc16);
               rem_in = '0;
               mcnt_in = '0;
               ok_in = 1'b0;
               // cursor moves resolve here
               case (req_op)
                  OP_FORWARD: if ((9'(cursor_ff) + 9'd1) < used_ff) begin
                     cursor_in = cursor_ff + 8'd1;
                     ok_in = 1'b1;
                  end
                  OP_BACK: if (cursor_ff != '0) begin
                     cursor_in = cursor_ff - 8'd1;
                     ok_in = 1'b1;
                  end
                  OP_BEGIN: if (used_ff != '0) begin
                     cursor_in = '0;
                     ok_in = 1'b1;
                  end
                  OP_END: if (used_ff != '0) begin
                     cursor_in = 8'(used_ff - 9'd1);
                     ok_in = 1'b1;
                  end
                  default: ;
               endcase
            end
         end
         ST_MOD: begin
            // bucket = sum mod TABLE_SIZE by reciprocal multiply, split in two halves
            case (mcnt_ff)
               4'd0: acc_in = 67'(sum_ff) * 67'(RECIP_LO);
               4'd1: acc_in = acc_ff + ((67'(sum_ff) * 67'(RECIP_HI)) << 17);
               4'd2: begin
                  // remainder is below twice the table size here
                  qv = 34'(acc_ff >> RSH);
                  rr_in = (BW+1)'(34'(sum_ff) - qv * 34'(TABLE_SIZE));
               end
               default: rem_in = (rr_ff >= TS_VAL) ? BW'(rr_ff - TS_VAL) : rr_ff[BW-1:0];
            endcase
            mcnt_in = mcnt_ff + 4'd1;
         end
         ST_HEAD_RD: head_rd_en = 1'b1;
         ST_HEAD_CHK: begin
            empty_in = head_q[8];
            if (!head_q[8]) begin
               ent_rd_en = 1'b1;
               ent_raddr = head_q[7:0];
               p_in = head_q[7:0];
            end
         end
         ST_ENT_CHK: begin
            if (hit) begin
               cursor_in = p_ff;
               case (op_ff)
                  OP_LOOKUP: ok_in = 1'b1;
                  OP_DELETE: if (!ent_q.del) begin
                     ent_we = 1'b1;
                     ent_wdata.del = 1'b1;
                     if (live_ff != '0) live_in = live_ff - 9'd1;
                     ok_in = 1'b1;
                  end
                  default: ;
               endcase
            end else if (last) begin
               hold_in = ent_q;
            end else begin
               ent_rd_en = 1'b1;
               ent_raddr = ent_q.next[7:0];
               p_in = ent_q.next[7:0];
            end
         end
         ST_APPEND: begin
            ent_we = 1'b1;
            ent_waddr = used_ff[7:0];
            ent_wdata = '{key: key_ff, next: NIL_LINK, del: 1'b0};
            head_we = empty_ff;
            head_wdata = {1'b0, used_ff[7:0]};
            used_in = used_ff + 9'd1;
            live_in = live_ff + 9'd1;
            ok_in = 1'b1;
         end
         ST_LINK: begin
            // point the old chain tail at the new entry
            ent_we = 1'b1;
            ent_waddr = p_ff;
            ent_wdata = '{key: hold_ff.key, next: used_ff - 9'd1, del: hold_ff.del};
         end
         ST_RD_CUR: begin
            ent_rd_en = 1'b1;
            ent_raddr = cursor_ff;
         end
         ST_RESP: begin
            rsp_data_in = '{success: ok_ff, cursor_position: cursor_ff,
                            cursor_entry_deleted: (used_ff != '0) && ent_q.del,
                            live_entries: live_ff, used_entries: used_ff};
         end
         default: ;
      endcase
   end

   // response register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_ch.ready) rsp_valid_in = 1'b0;
      if (rsp_load) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         used_ff      <= '0;
         live_ff      <= '0;
         cursor_ff    <= '0;
         ok_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         used_ff      <= used_in;
         live_ff      <= live_in;
         cursor_ff    <= cursor_in;
         ok_ff        <= ok_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff    <= op_in;
      key_ff   <= key_in;
      sum_ff   <= sum_in;
      acc_ff   <= acc_in;
      rr_ff    <= rr_in;
      rem_ff   <= rem_in;
      mcnt_ff  <= mcnt_in;
      p_ff     <= p_in;
      hold_ff  <= hold_in;
      empty_ff <= empty_in;
      if (rsp_load) rsp_data_ff <= rsp_data_in;
   end

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.data  = rsp_data_ff;

endmodule
`default_nettype wire

FILE: hdl/chkt_checker.sv
// Port-level checker for the chained hash key table unit, with its bind
`timescale 1ns / 1ps
`default_nettype none
`include "chained_hash_key_table_unit_assert.svh"
module chkt_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic [7:0] rsp_cursor,
   input wire logic       rsp_del,
   input wire logic [8:0] rsp_live,
   input wire logic [8:0] rsp_used
);
   // a response stays offered until taken
   `CHKT_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
   // live count never exceeds entries used, which never exceed capacity
   `CHKT_ASSERT_IMP(a_counts, clock, reset, rsp_valid, (rsp_live <= rsp_used) && (rsp_used <= 9'd256))
   // empty table reports cursor at zero and no deleted mark
   `CHKT_ASSERT_IMP(a_empty, clock, reset, rsp_valid && (rsp_used == 9'd0), (rsp_cursor == 8'd0) && !rsp_del)
   // no response right after reset
   `CHKT_ASSERT_IMP(a_reset, clock, 1'b0, $past(reset), !rsp_valid)
endmodule

bind chained_hash_key_table_unit chkt_checker u_chkt_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_valid  (rsp_ch.valid),
   .rsp_ready  (rsp_ch.ready),
   .rsp_cursor (rsp_ch.data.cursor_position),
   .rsp_del    (rsp_ch.data.cursor_entry_deleted),
   .rsp_live   (rsp_ch.data.live_entries),
   .rsp_used   (rsp_ch.data.used_entries)
);
`default_nettype wire

FILE: dv/tb_chained_hash_key_table_unit.sv
// Testbench for the chained hash key table unit: directed table, then random operations
`timescale 1ns / 1ps
`default_nettype none
module tb_chained_hash_key_table_unit;
   import chkt_pkg::*;

   localparam int unsigned TBL_SIZE = 256;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   err_count = 0;

   chkt_req_if req_ch ();
   chkt_rsp_if rsp_ch ();

   chained_hash_key_table_unit #(.TABLE_SIZE(TBL_SIZE)) dut (
      .clock (clock),
      .reset (reset),
      .req_ch(req_ch.sink),
      .rsp_ch(rsp_ch.source)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Shadow copy of the table
   logic [47:0] shadow_keys [CAPACITY];
   logic        shadow_dead [CAPACITY];
   int unsigned shadow_used;
   int unsigned shadow_live;
   int unsigned shadow_cursor;

   rsp_data_type expected_rsp_q[$];
   logic         rsp_checked_q[$];  // declared but never written or read
   rsp_data_type typed_rsp_q[$];
   logic         typed_valid_q[$];

   // Insertion-order search equals chain-order search: each chain is
   // appended in insertion order and keys are unique.
   function automatic int find_key(logic [47:0] k);
      for (int i = 0; i < shadow_used; i++)
         if (shadow_keys[i] == k) return i;
      return -1;
   endfunction

   function automatic rsp_data_type predict_table_op(req_data_type rq);
      rsp_data_type r;
      logic [47:0]  k;
      int           idx;
      logic         ok;
      k   = {rq.key_crc16, rq.key_crc32};
      ok  = 1'b0;
      idx = find_key(k);
      case (op_type'(rq.operation))
         OP_LOOKUP: begin
            if (idx >= 0) begin
               shadow_cursor = idx;
               ok = 1'b1;
            end
         end
         OP_INSERT: begin
            if (shadow_used < CAPACITY) begin
               if (idx >= 0) begin
                  shadow_cursor = idx;
               end else begin
                  shadow_keys[shadow_used] = k;
                  shadow_dead[shadow_used] = 1'b0;
                  shadow_used++;
                  shadow_live++;
                  ok = 1'b1;
               end
            end
         end
         OP_DELETE: begin
            if (idx >= 0) begin
               shadow_cursor = idx;
               if (!shadow_dead[idx]) begin
                  shadow_dead[idx] = 1'b1;
                  shadow_live--;
                  ok = 1'b1;
               end
            end
         end
         OP_FORWARD: begin
            if (shadow_used > 0 && shadow_cursor + 1 < shadow_used) begin
               shadow_cursor++;
               ok = 1'b1;
            end
         end
         OP_BACK: begin
            if (shadow_cursor > 0) begin
               shadow_cursor--;
               ok = 1'b1;
            end
         end
         OP_BEGIN: begin
            if (shadow_used > 0) begin
               shadow_cursor = 0;
               ok = 1'b1;
            end
         end
         OP_END: begin
            if (shadow_used > 0) begin
               shadow_cursor = shadow_used - 1;
               ok = 1'b1;
            end
         end
         default: ;
      endcase
      r.success              = ok;
      r.cursor_position      = shadow_cursor[7:0];
      r.cursor_entry_deleted = (shadow_used > 0) ? shadow_dead[shadow_cursor] : 1'b0;
      r.live_entries         = shadow_live[8:0];
      r.used_entries         = shadow_used[8:0];
      return r;
   endfunction

   // Directed rows; typed expectation only where obvious
   typedef struct {
      op_type       op;
      logic [31:0]  c32;
      logic [15:0]  c16;
      logic         typed;
      rsp_data_type rsp;
   } directed_row_type;

   directed_row_type directed_rows[] = '{
      '{OP_FORWARD, 32'h0, 16'h0, 1'b1, '{1'b0, 8'd0, 1'b0, 9'd0, 9'd0}},
      '{OP_BACK,    32'h0, 16'h0, 1'b1, '{1'b0, 8'd0, 1'b0, 9'd0, 9'd0}},
      '{OP_BEGIN,   32'h0, 16'h0, 1'b1, '{1'b0, 8'd0, 1'b0, 9'd0, 9'd0}},
      '{OP_END,     32'h0, 16'h0, 1'b1, '{1'b0, 8'd0, 1'b0, 9'd0, 9'd0}},
      '{OP_LOOKUP,  32'h0, 16'h0, 1'b1, '{1'b0, 8'd0, 1'b0, 9'd0, 9'd0}},
      '{OP_DELETE,  32'h0, 16'h0, 1'b1, '{1'b0, 8'd0, 1'b0, 9'd0, 9'd0}},
      '{OP_NONE,    32'h0, 16'h0, 1'b1, '{1'b0, 8'd0, 1'b0, 9'd0, 9'd0}},
      '{OP_INSERT,  32'h0, 16'h0, 1'b1, '{1'b1, 8'd0, 1'b0, 9'd1, 9'd1}},
      '{OP_INSERT,  32'hFFFF_FFFF, 16'hFFFF, 1'b0, '0},
      // same bucket as the maximum key: 0xFFFFFFFF+0xFFFF mod 256 = 0xFE
      '{OP_INSERT,  32'h0000_00FE, 16'h0000, 1'b0, '0},
      '{OP_INSERT,  32'h0000_00FD, 16'h0001, 1'b0, '0},
      '{OP_INSERT,  32'h0000_00FE, 16'h0000, 1'b0, '0},
      '{OP_LOOKUP,  32'h0000_00FD, 16'h0001, 1'b0, '0},
      '{OP_LOOKUP,  32'h0000_00FC, 16'h0002, 1'b0, '0},
      '{OP_DELETE,  32'h0000_00FE, 16'h0000, 1'b0, '0},
      '{OP_DELETE,  32'h0000_00FE, 16'h0000, 1'b0, '0},
      '{OP_LOOKUP,  32'h0000_00FE, 16'h0000, 1'b0, '0},
      '{OP_INSERT,  32'h0000_00FE, 16'h0000, 1'b0, '0},
      '{OP_END,     32'h0, 16'h0, 1'b0, '0},
      '{OP_FORWARD, 32'h0, 16'h0, 1'b0, '0},
      '{OP_BEGIN,   32'hFFFF_FFFF, 16'hFFFF, 1'b0, '0},
      '{OP_BACK,    32'h0, 16'h0, 1'b0, '0},
      '{OP_FORWARD, 32'h0, 16'h0, 1'b0, '0},
      '{OP_DELETE,  32'hFFFF_FFFF, 16'hFFFF, 1'b0, '0}
   };

   function automatic int gap_len();
      int p;
      p = $urandom_range(0, 99);
      if (p < 45) return 0;
      if (p < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Random key biased toward a small reused pool and tight buckets
   logic [47:0] key_pool[$];

   function automatic logic [47:0] pick_key();
      int p;
      logic [47:0] k;
      p = $urandom_range(0, 99);
      if (p < 45 && key_pool.size() > 0) return key_pool[$urandom_range(0, key_pool.size() - 1)];
      if (p < 70) begin
         k[15:0]  = 16'($urandom_range(0, 3));
         k[47:16] = $urandom_range(0, 7) * 256;  // collide on a few buckets
         k = {k[15:0], k[47:16]};
      end else begin
         k = {16'($urandom), 32'($urandom)};
      end
      key_pool.push_back(k);
      return k;
   endfunction

   // Send one transaction, predict it, wait for acceptance; valid stays up
   // after acceptance so back-to-back requests need no idle cycle
   task automatic send_request(req_data_type rq, logic typed, rsp_data_type trsp);
      int g;
      g = gap_len();
      if (g > 0) begin
         req_ch.valid <= 1'b0;
         repeat (g) @(negedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.data  <= rq;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      expected_rsp_q.push_back(predict_table_op(rq));
      typed_valid_q.push_back(typed);
      typed_rsp_q.push_back(trsp);
      @(negedge clock);
   endtask

   task automatic drain_table();
      req_ch.valid <= 1'b0;
      @(negedge clock);
      while (expected_rsp_q.size() > 0) @(negedge clock);
   endtask

   // Stimulus
   initial begin
      req_data_type rq;
      op_type       op;
      int           p;
      req_ch.valid = 1'b0;
      req_ch.data  = '0;
      foreach (shadow_dead[i]) begin
         shadow_dead[i] = 1'b0;
         shadow_keys[i] = '0;
      end
      shadow_used = 0;
      shadow_live = 0;
      shadow_cursor = 0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (directed_rows[i]) begin
         rq.operation = directed_rows[i].op;
         rq.key_crc32 = directed_rows[i].c32;
         rq.key_crc16 = directed_rows[i].c16;
         send_request(rq, directed_rows[i].typed, directed_rows[i].rsp);
      end
      drain_table();

      // Random phase; a fill burst drives the table to full midway
      for (int n = 0; n < 900; n++) begin
         p = $urandom_range(0, 99);
         if (n >= 300 && n < 560) op = OP_INSERT;
         else if (p < 30) op = OP_INSERT;
         else if (p < 50) op = OP_LOOKUP;
         else if (p < 65) op = OP_DELETE;
         else op = op_type'($urandom_range(3, 7));
         if (n >= 300 && n < 560 && $urandom_range(0, 3) != 0) begin
            rq.key_crc32 = $urandom;
            rq.key_crc16 = 16'($urandom);
         end else begin
            {rq.key_crc16, rq.key_crc32} = pick_key();
         end
         rq.operation = op;
         send_request(rq, 1'b0, '0);
         if (n == 150 || n == 600) drain_table();
      end
      drain_table();
      repeat (300) @(posedge clock);
      if (err_count == 0) $display("end of test: clean");
      else $display("end of test: mismatches");
      $finish;
   end

   // Result side: random stalls, check against the oldest expectation
   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_ch.ready <= (gap_len() == 0) || ($urandom_range(0, 1) == 1);
      end
   end

   always @(posedge clock) begin
      rsp_data_type e;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_rsp_q.size() == 0) begin
            $error("unexpected response %p", rsp_ch.data);
            err_count++;
         end else begin
            e = expected_rsp_q.pop_front();
            if (typed_valid_q.pop_front()) begin
               if (typed_rsp_q[0] != e) begin
                  $error("table row disagrees with predictor: %p vs %p", typed_rsp_q[0], e);
                  err_count++;
               end
            end
            void'(typed_rsp_q.pop_front());
            if (rsp_ch.data.success !== e.success) begin
               $error("success exp %0d got %0d", e.success, rsp_ch.data.success);
               err_count++;
            end
            if (rsp_ch.data.cursor_position !== e.cursor_position) begin
               $error("cursor_position exp %0d got %0d", e.cursor_position,
                      rsp_ch.data.cursor_position);
               err_count++;
            end
            if (rsp_ch.data.cursor_entry_deleted !== e.cursor_entry_deleted) begin
               $error("cursor_entry_deleted exp %0d got %0d", e.cursor_entry_deleted,
                      rsp_ch.data.cursor_entry_deleted);
               err_count++;
            end
            if (rsp_ch.data.live_entries !== e.live_entries) begin
               $error("live_entries exp %0d got %0d", e.live_entries, rsp_ch.data.live_entries);
               err_count++;
            end
            if (rsp_ch.data.used_entries !== e.used_entries) begin
               $error("used_entries exp %0d got %0d", e.used_entries, rsp_ch.data.used_entries);
               err_count++;
            end
         end
      end
   end

   // Watchdog
   initial begin
      #4_000_000;
      $display("end of test: mismatches");
      $finish;
   end

endmodule
`default_nettype wire
